// ----- rtl/mqs_pkg.sv -----
// ----------------------------------------------------------------------------
// mqs_pkg
// Shared constants and types of the multi-queue shared store: store sizes,
// operation and status codes, and the link store access bundles.
// ----------------------------------------------------------------------------
package mqs_pkg;

    localparam int SLOTS      = 64;
    localparam int QUEUES     = 8;
    localparam int DATA_WIDTH = 32;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam int QSEL_W = 3;

    // null link: one past the last slot
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(SLOTS);

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_PEEK = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [LINK_W-1:0] data;
    } link_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } link_rd_t;

endpackage

// ----- rtl/multi_queue_shared_store.sv -----
// ----------------------------------------------------------------------------
// multi_queue_shared_store
// Eight FIFO queues kept in one shared store of 64 slots, chained through a
// next-slot table, with unused slots on a free chain.
//
// Usage: drive kind (push, pop, peek), queue_sel and push_value with start.
// An operation is taken at a rising edge where start is high and busy is
// low. Its result (head_value, status, store_full) shows for exactly one
// cycle with done, registered on the way from the work state to the done
// state. busy stays high through the work and done states and drops on the
// return to idle, so no new operation is taken until the result has shown.
// The work state serves the single-write link table: a push to a non-empty
// queue writes two link entries, one at the transfer edge and one at the
// following edge, and pop uses the registered link of the head slot in it.
// The receiver cannot stall: results must be taken when done is high.
// Reset empties every queue and chains all slots onto the free list; no
// clearing pass is needed, so operations may start right after reset.
// ----------------------------------------------------------------------------
module multi_queue_shared_store (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [2:0]         queue_sel,
    input  logic signed [31:0] push_value,
    output logic               done,
    output logic signed [31:0] head_value,
    output logic [1:0]         status,
    output logic               store_full
);

    import mqs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [LINK_W-1:0] qhead_reg [QUEUES];
    logic [SLOT_W-1:0] qtail_reg [QUEUES];
    logic [LINK_W-1:0] free_head_reg;
    logic [LINK_W-1:0] free_head_next;

    logic [1:0]        op_kind_reg;
    logic [QSEL_W-1:0] op_q_reg;
    logic [SLOT_W-1:0] op_slot_reg;
    logic              op_err_reg;

    logic               done_reg;
    logic signed [31:0] head_value_reg;
    logic [1:0]         status_reg;
    logic               store_full_reg;

    logic                  accept;
    logic [LINK_W-1:0]     cur_head;
    logic                  head_nil;
    logic                  free_nil;
    logic [LINK_W-1:0]     rd_link;
    logic [DATA_WIDTH-1:0] rd_data;
    link_wr_t              link_wr;
    link_rd_t              link_rd;
    logic                  data_wr_en;
    logic                  data_rd_en;
    logic [SLOT_W-1:0]     data_rd_addr;

    assign accept   = start && (state_reg == ST_IDLE);
    assign cur_head = qhead_reg[queue_sel];
    assign head_nil = (cur_head == NIL_LINK);
    assign free_nil = (free_head_reg == NIL_LINK);

    // memory control: first accesses at the transfer edge, second one after
    always_comb
    begin
        link_wr      = '0;
        link_rd      = '0;
        data_wr_en   = 1'b0;
        data_rd_en   = 1'b0;
        data_rd_addr = cur_head[SLOT_W-1:0];
        if (accept)
        begin
            unique case (kind)
                KIND_PUSH:
                begin
                    if (!free_nil)
                    begin
                        link_rd.en   = 1'b1;
                        link_rd.addr = free_head_reg[SLOT_W-1:0];
                        data_wr_en   = 1'b1;
                        // append behind the current tail
                        link_wr.en   = !head_nil;
                        link_wr.addr = qtail_reg[queue_sel];
                        link_wr.data = free_head_reg;
                    end
                end
                KIND_POP:
                begin
                    link_rd.en   = !head_nil;
                    link_rd.addr = cur_head[SLOT_W-1:0];
                end
                KIND_PEEK:
                begin
                    data_rd_en = !head_nil;
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == ST_WORK && !op_err_reg)
        begin
            unique case (op_kind_reg)
                KIND_PUSH:
                begin
                    link_wr.en   = 1'b1;
                    link_wr.addr = op_slot_reg;
                    link_wr.data = NIL_LINK;
                end
                KIND_POP:
                begin
                    // return the slot to the front of the free chain
                    link_wr.en   = 1'b1;
                    link_wr.addr = op_slot_reg;
                    link_wr.data = free_head_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        free_head_next = free_head_reg;
        if (state_reg == ST_WORK && !op_err_reg)
        begin
            unique case (op_kind_reg)
                KIND_PUSH: free_head_next = rd_link;
                KIND_POP:  free_head_next = LINK_W'(op_slot_reg);
                default:   free_head_next = free_head_reg;
            endcase
        end
    end

    mqs_link_store u_link (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (link_wr),
        .rd      (link_rd),
        .rd_link (rd_link)
    );

    mqs_ram #(
        .ADDR_W (SLOT_W),
        .DATA_W (DATA_WIDTH)
    ) u_data (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (free_head_reg[SLOT_W-1:0]),
        .wr_data (DATA_WIDTH'(push_value)),
        .rd_en   (data_rd_en),
        .rd_addr (data_rd_addr),
        .rd_data (rd_data)
    );

    // tail pointers: read only for non-empty queues, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_PUSH && !free_nil)
        begin
            qtail_reg[queue_sel] <= free_head_reg[SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_kind_reg <= kind;
            op_q_reg    <= queue_sel;
            op_slot_reg <= (kind == KIND_PUSH) ? free_head_reg[SLOT_W-1:0]
                                               : cur_head[SLOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_head_reg  <= '0;
            op_err_reg     <= 1'b0;
            done_reg       <= 1'b0;
            head_value_reg <= '0;
            status_reg     <= STAT_OK;
            store_full_reg <= 1'b0;
            for (int i = 0; i < QUEUES; i++)
            begin
                qhead_reg[i] <= NIL_LINK;
            end
        end
        else
        begin
            done_reg      <= 1'b0;
            free_head_reg <= free_head_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_WORK;
                        unique case (kind)
                            KIND_PUSH:
                            begin
                                op_err_reg <= free_nil;
                                if (!free_nil && head_nil)
                                begin
                                    qhead_reg[queue_sel] <= free_head_reg;
                                end
                            end
                            KIND_POP, KIND_PEEK:
                            begin
                                op_err_reg <= head_nil;
                            end
                            default:
                            begin
                                op_err_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_WORK:
                begin
                    state_reg      <= ST_DONE;
                    done_reg       <= 1'b1;
                    store_full_reg <= (free_head_next == NIL_LINK);
                    head_value_reg <= '0;
                    status_reg     <= STAT_OK;
                    unique case (op_kind_reg)
                        KIND_PUSH:
                        begin
                            if (op_err_reg)
                            begin
                                status_reg <= STAT_FULL;
                            end
                        end
                        KIND_POP:
                        begin
                            if (op_err_reg)
                            begin
                                status_reg <= STAT_EMPTY;
                            end
                            else
                            begin
                                qhead_reg[op_q_reg] <= rd_link;
                            end
                        end
                        KIND_PEEK:
                        begin
                            if (op_err_reg)
                            begin
                                status_reg <= STAT_EMPTY;
                            end
                            else
                            begin
                                head_value_reg <= 32'(rd_data);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_DONE:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign head_value = head_value_reg;
    assign status     = status_reg;
    assign store_full = store_full_reg;

endmodule

// ----- rtl/mqs_ram.sv -----
// ----------------------------------------------------------------------------
// mqs_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mqs_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/mqs_link_store.sv -----
// ----------------------------------------------------------------------------
// mqs_link_store
// Next-slot link table. An entry never written reads as its reset link,
// the following slot (null for the last slot), tracked by one valid bit per
// entry.
// ----------------------------------------------------------------------------
module mqs_link_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mqs_pkg::link_wr_t             wr,
    input  mqs_pkg::link_rd_t             rd,
    output logic [mqs_pkg::LINK_W-1:0]    rd_link
);

    import mqs_pkg::*;

    logic [LINK_W-1:0] link_mem [SLOTS];
    logic [SLOTS-1:0]  vld_reg;
    logic [LINK_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic [SLOT_W-1:0] rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            link_mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= link_mem[rd.addr];
            rd_addr_reg <= rd.addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_vld_reg <= vld_reg[rd.addr];
            end
        end
    end

    // unwritten entry: link to the next slot, which is null past the last one
    assign rd_link = rd_vld_reg ? rd_data_reg
                                : LINK_W'(rd_addr_reg) + LINK_W'(1);

endmodule

// ----- rtl/mqs_checker.sv -----
// ----------------------------------------------------------------------------
// mqs_checker
// Port-level checks of the multi-queue shared store: operation timing and
// consistency of the result flags.
// ----------------------------------------------------------------------------
module mqs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status,
    input logic       store_full
);

    import mqs_pkg::*;

    // every transfer is answered with a result on done
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result did not follow the transfer after two cycles");

    // done is shown only while busy is high
    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done shown while not busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // a refused push means the store has no free slot
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_FULL) |-> store_full)
        else $error("push refused while store not full");

endmodule

bind multi_queue_shared_store mqs_checker u_mqs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .store_full (store_full)
);
